>>> rtl/core/itf_pkg.sv
`timescale 1ns / 1ps
package itf_pkg;
	localparam int unsigned MAX_FIELD = 60;
	localparam int unsigned MAX_RESULTS = 64;

	typedef enum logic [2:0] {
		KIND_SDEC = 3'd0,
		KIND_UDEC = 3'd1,
		KIND_HEXL = 3'd2,
		KIND_HEXU = 3'd3,
		KIND_OCT  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SIZE_INT   = 2'd0,
		SIZE_SHORT = 2'd1,
		SIZE_LONG  = 2'd2
	} size_t_t;

	// Digit unit radix select
	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_HEX = 2'd1,
		BASE_OCT = 2'd2
	} base_t;

	// Digit generator to emitter hand-off
	typedef struct packed {
		logic       start;
		logic [5:0] pad;
		logic [5:0] prec_zeros;
		logic [4:0] ndig;
		logic [1:0] plen;
		logic [7:0] pre0;
		logic [7:0] pre1;
		logic       pad_zero;
		logic       left;
	} emit_ctl_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		begin
			if (d < 4'd10) c = 8'h30 + {4'd0, d};
			else if (upper) c = 8'h37 + {4'd0, d};
			else c = 8'h57 + {4'd0, d};
			return c;
		end
	endfunction
endpackage

>>> rtl/core/itf_digits.sv
`timescale 1ns / 1ps
// Shared digit unit: decimal runs a shift-and-add-3 binary to BCD conversion
// over all 64 input bits, then peels one BCD digit a cycle; hex and octal peel one digit a
// cycle by shifting. Digits stored least significant first.
module itf_digits import itf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] mag,
	input  logic [1:0]  base_sel,   // BASE_DEC, BASE_HEX, BASE_OCT
	input  logic        upper,
	output logic        done,
	output logic [4:0]  ndig,
	input  logic [4:0]  rd_idx,
	output logic [7:0]  rd_char
);
	logic [63:0] val_q;
	logic [79:0] bcd_q;
	logic [79:0] bcd_adj;
	logic [5:0]  bit_q;
	logic        busy_q;
	logic        conv_q;
	logic [4:0]  cnt_q;
	logic [1:0]  base_q;
	logic        upper_q;
	logic [7:0]  dig_q [32];
	logic [3:0]  dval;

	assign ndig = cnt_q;
	assign rd_char = dig_q[rd_idx];
	assign done = !busy_q;

	always_comb begin
		if (base_q == BASE_HEX) dval = val_q[3:0];
		else dval = {1'b0, val_q[2:0]};
	end

	// add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < 20; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			conv_q <= 1'b0;
			cnt_q <= '0;
			bit_q <= '0;
		end else if (start) begin
			busy_q <= (mag != 64'd0);
			conv_q <= (base_sel == BASE_DEC) && (mag != 64'd0);
			cnt_q <= '0;
			bit_q <= '0;
		end else if (busy_q) begin
			if (conv_q) begin
				bit_q <= bit_q + 6'd1;
				if (bit_q == 6'd63) conv_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 5'd1;
				if (base_q == BASE_DEC) busy_q <= ((bcd_q >> 4) != 80'd0);
				else if (base_q == BASE_HEX) busy_q <= ((val_q >> 4) != 64'd0);
				else busy_q <= ((val_q >> 3) != 64'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= mag;
			bcd_q <= '0;
			base_q <= base_sel;
			upper_q <= upper;
		end else if (busy_q) begin
			if (conv_q) begin
				bcd_q <= {bcd_adj[78:0], val_q[63]};
				val_q <= {val_q[62:0], 1'b0};
			end else if (base_q == BASE_DEC) begin
				dig_q[cnt_q] <= digit_char(bcd_q[3:0], 1'b0);
				bcd_q <= bcd_q >> 4;
			end else begin
				dig_q[cnt_q] <= digit_char(dval, upper_q);
				if (base_q == BASE_HEX) val_q <= val_q >> 4;
				else val_q <= val_q >> 3;
			end
		end
	end
endmodule

>>> rtl/core/itf_emit.sv
`timescale 1ns / 1ps
// Character sequencer: pad, prefix, zero pad, precision zeros, digits, right pad.
module itf_emit import itf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  emit_ctl_t  ctl,
	input  logic [7:0] dig_char,
	output logic [4:0] dig_idx,
	output logic       busy,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_char,
	output logic       m_cvalid,
	output logic       m_last
);
	typedef enum logic [6:0] {
		E_IDLE = 7'b0000001,
		E_LPAD = 7'b0000010,
		E_PRE  = 7'b0000100,
		E_ZPAD = 7'b0001000,
		E_PREC = 7'b0010000,
		E_DIG  = 7'b0100000,
		E_RPAD = 7'b1000000
	} est_t;

	est_t       st_q;
	emit_ctl_t  c_q;
	logic [5:0] cnt_q;
	logic [1:0] pi_q;
	logic       any_q;
	logic       take;
	logic [7:0] ch;
	logic       fin;
	logic       l_rem, p_rem, z_rem, q_rem, d_rem, r_rem;

	assign busy = (st_q != E_IDLE) || m_tvalid;
	assign take = !m_tvalid || m_tready;
	assign dig_idx = 5'(cnt_q - 6'd1);

	// remaining-work indicators after the current state
	always_comb begin
		l_rem = !c_q.left && !c_q.pad_zero && c_q.pad != 0;
		p_rem = c_q.plen != 0;
		z_rem = c_q.pad_zero && c_q.pad != 0;
		q_rem = c_q.prec_zeros != 0;
		d_rem = c_q.ndig != 0;
		r_rem = c_q.left && c_q.pad != 0;
	end

	function automatic est_t next_from(input est_t s, input logic l, input logic p,
		input logic z, input logic q, input logic d, input logic r);
		est_t n;
		begin
			n = E_IDLE;
			if (r && s != E_RPAD) n = E_RPAD;
			if (d && s != E_DIG && s != E_RPAD) n = E_DIG;
			if (q && (s == E_IDLE || s == E_LPAD || s == E_PRE || s == E_ZPAD)) n = E_PREC;
			if (z && (s == E_IDLE || s == E_LPAD || s == E_PRE)) n = E_ZPAD;
			if (p && (s == E_IDLE || s == E_LPAD)) n = E_PRE;
			if (l && s == E_IDLE) n = E_LPAD;
			return n;
		end
	endfunction

	function automatic logic [5:0] len_of(input est_t s, input emit_ctl_t c);
		logic [5:0] n;
		begin
			case (s)
				E_LPAD, E_ZPAD, E_RPAD: n = c.pad;
				E_PRE:  n = {4'd0, c.plen};
				E_PREC: n = c.prec_zeros;
				E_DIG:  n = {1'b0, c.ndig};
				default: n = 6'd0;
			endcase
			return n;
		end
	endfunction

	always_comb begin
		case (st_q)
			E_LPAD, E_RPAD: ch = 8'h20;
			E_PRE:  ch = (pi_q == 2'd0) ? c_q.pre0 : c_q.pre1;
			E_ZPAD, E_PREC: ch = 8'h30;
			E_DIG:  ch = dig_char;
			default: ch = 8'h00;
		endcase
	end

	est_t nxt;
	always_comb begin
		nxt = next_from(st_q, l_rem, p_rem, z_rem, q_rem, d_rem, r_rem);
		fin = (cnt_q == 6'd1) && (nxt == E_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			m_tvalid <= 1'b0;
			m_char <= 8'h00;
			m_cvalid <= 1'b0;
			m_last <= 1'b0;
			cnt_q <= '0;
			pi_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (st_q == E_IDLE) begin
				if (ctl.start) begin
					st_q <= next_from(E_IDLE, !ctl.left && !ctl.pad_zero && ctl.pad != 0,
						ctl.plen != 0, ctl.pad_zero && ctl.pad != 0, ctl.prec_zeros != 0,
						ctl.ndig != 0, ctl.left && ctl.pad != 0);
					cnt_q <= len_of(next_from(E_IDLE, !ctl.left && !ctl.pad_zero &&
						ctl.pad != 0, ctl.plen != 0, ctl.pad_zero && ctl.pad != 0,
						ctl.prec_zeros != 0, ctl.ndig != 0, ctl.left && ctl.pad != 0), ctl);
					pi_q <= '0;
					any_q <= 1'b0;
					if (next_from(E_IDLE, !ctl.left && !ctl.pad_zero && ctl.pad != 0,
						ctl.plen != 0, ctl.pad_zero && ctl.pad != 0, ctl.prec_zeros != 0,
						ctl.ndig != 0, ctl.left && ctl.pad != 0) == E_IDLE) begin
						// empty text: one marker result
						m_tvalid <= 1'b1;
						m_char <= 8'h00;
						m_cvalid <= 1'b0;
						m_last <= 1'b1;
					end
				end else if (m_tvalid && m_tready) begin
					m_tvalid <= 1'b0;
				end
			end else if (take) begin
				m_tvalid <= 1'b1;
				m_char <= ch;
				m_cvalid <= 1'b1;
				m_last <= fin;
				any_q <= 1'b1;
				if (st_q == E_PRE) pi_q <= pi_q + 2'd1;
				if (cnt_q == 6'd1) begin
					st_q <= nxt;
					cnt_q <= len_of(nxt, c_q);
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == E_IDLE && ctl.start) c_q <= ctl;
	end

`ifndef ASSERT_OFF
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_last) |=> (st_q == E_IDLE))
		else $error("last sent while work remains");
	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_cvalid) |-> m_last)
		else $error("empty marker without last");
	a_prefix_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == E_PRE) |-> (pi_q < c_q.plen))
		else $error("prefix index overrun");
	a_any: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_cvalid) |-> !any_q)
		else $error("marker after characters");
`endif
endmodule

>>> rtl/core/integer_text_formatter.sv
`timescale 1ns / 1ps
// integer_text_formatter: one printf-style integer conversion per request.
// Input channel s_axis_*: a request carries number, size mode, flags, field
// width and an optional precision in tdata, and the conversion kind in tuser.
// It is accepted when s_axis_tvalid and s_axis_tready are both high; tready is
// low while a request is in work, so requests are handled one at a time.
// Output channel m_axis_*: one ASCII character per transfer, tlast on the final
// one. A text that comes out empty yields one marker transfer with tuser=0.
// Flow: decimal first runs a shift-and-add-3 binary to BCD conversion, then
// takes one digit per cycle (up to 20); hex and octal skip the conversion and
// take one digit per cycle (up to 16 or 22). Characters then leave at one per
// cycle while m_axis_tready is high, up to 62 of them. A request holds the
// block through its digit phase, the S_SEND and S_WAIT hand-off states and the
// sending of all of its characters.
// Output stalls (m_axis_tready low) hold the current character and freeze the
// sequencer; nothing is dropped. Reset clears all control state and any
// request in work is lost.
module integer_text_formatter import itf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bits from low: number[63:0], size_mode[65:64], flag_left[66], flag_plus[67],
	// flag_space[68], flag_alt[69], flag_zero[70], field_width[76:71],
	// has_min_digits[77], min_digits[83:78], zero fill to 88
	input  logic [87:0] s_axis_tdata,
	// kind[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_char[7:0]
	output logic        m_axis_tuser,   // char_valid
	output logic        m_axis_tlast
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIG  = 4'b0010,
		S_SEND = 4'b0100,
		S_WAIT = 4'b1000
	} st_t;

	st_t         st_q;
	logic [2:0]  kind_q;
	logic        left_q, plus_q, space_q, alt_q, zero_q, hasp_q;
	logic [5:0]  fw_q, md_q;
	logic        neg_q;
	logic [63:0] mag_q;
	logic        go_q;
	logic        dig_done;
	logic [4:0]  ndig;
	logic [4:0]  rd_idx;
	logic [7:0]  rd_char;
	logic        emit_busy;
	emit_ctl_t   ctl;

	logic [2:0]  in_kind;
	logic [63:0] in_num, raw, m;
	logic [1:0]  in_size;
	logic [5:0]  in_fw, in_md;
	logic        sbit;

	assign s_axis_tready = (st_q == S_IDLE);

	always_comb begin
		in_kind = s_axis_tuser;
		if (in_kind > KIND_OCT) in_kind = KIND_UDEC;
		in_num = s_axis_tdata[63:0];
		in_size = s_axis_tdata[65:64];
		in_fw = s_axis_tdata[76:71];
		in_md = s_axis_tdata[83:78];
		if (in_fw > 6'(MAX_FIELD)) in_fw = 6'(MAX_FIELD);
		if (in_md > 6'(MAX_FIELD)) in_md = 6'(MAX_FIELD);
		case (in_size)
			SIZE_SHORT: begin raw = {48'd0, in_num[15:0]}; sbit = in_num[15]; end
			SIZE_INT:   begin raw = {32'd0, in_num[31:0]}; sbit = in_num[31]; end
			default:    begin raw = in_num; sbit = in_num[63]; end
		endcase
		sbit = sbit && (in_kind == KIND_SDEC);
		m = raw;
		if (sbit) begin
			case (in_size)
				SIZE_SHORT: m = {48'd0, 16'(~raw[15:0] + 16'd1)};
				SIZE_INT:   m = {32'd0, 32'(~raw[31:0] + 32'd1)};
				default:    m = ~raw + 64'd1;
			endcase
		end
	end

	itf_digits u_dig (
		.clk(clk), .arst_n(arst_n), .start(go_q), .mag(mag_q),
		.base_sel((kind_q == KIND_OCT) ? BASE_OCT :
			((kind_q == KIND_HEXL || kind_q == KIND_HEXU) ? BASE_HEX : BASE_DEC)),
		.upper(kind_q == KIND_HEXU), .done(dig_done), .ndig(ndig),
		.rd_idx(rd_idx), .rd_char(rd_char)
	);

	// Build prefix and length figures once the digits are known.
	logic [1:0]  plen;
	logic [7:0]  p0, p1;
	logic [4:0]  nd;
	logic        zero_text;
	logic [5:0]  pz;
	logic [7:0]  body;
	always_comb begin
		plen = '0;
		p0 = 8'h00;
		p1 = 8'h00;
		if (kind_q == KIND_SDEC) begin
			if (neg_q) begin plen = 2'd1; p0 = 8'h2D; end
			else if (plus_q) begin plen = 2'd1; p0 = 8'h2B; end
			else if (space_q) begin plen = 2'd1; p0 = 8'h20; end
		end
		if ((kind_q == KIND_HEXL || kind_q == KIND_HEXU) && alt_q && mag_q != 64'd0) begin
			if (plen == 2'd0) begin
				p0 = 8'h30;
				p1 = (kind_q == KIND_HEXU) ? 8'h58 : 8'h78;
			end
			plen = plen + 2'd2;
		end
		// zero value gives one '0' unless precision zero
		zero_text = (mag_q == 64'd0) && !(hasp_q && md_q == 6'd0);
		nd = zero_text ? 5'd1 : ndig;
		pz = (hasp_q && md_q > {1'b0, nd}) ? md_q - {1'b0, nd} : 6'd0;
		if (kind_q == KIND_OCT && alt_q && pz == 6'd0 && !zero_text) pz = 6'd1;
		body = {6'd0, plen} + {2'd0, pz} + {3'd0, nd};
		ctl.start = (st_q == S_SEND);
		ctl.pad = ({2'd0, fw_q} > body) ? 6'({2'd0, fw_q} - body) : 6'd0;
		ctl.prec_zeros = pz;
		ctl.ndig = nd;
		ctl.plen = plen;
		ctl.pre0 = p0;
		ctl.pre1 = p1;
		ctl.pad_zero = !left_q && zero_q && !hasp_q;
		ctl.left = left_q;
	end

	// zero value reads a '0' at digit slot 0
	logic [4:0] e_idx;
	logic [7:0] e_char;
	assign rd_idx = e_idx;
	assign e_char = (mag_q == 64'd0) ? 8'h30 : rd_char;

	itf_emit u_emit (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .dig_char(e_char), .dig_idx(e_idx),
		.busy(emit_busy), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.m_char(m_axis_tdata), .m_cvalid(m_axis_tuser), .m_last(m_axis_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (st_q)
				S_IDLE: if (s_axis_tvalid) begin
					st_q <= S_DIG;
					go_q <= 1'b1;
				end
				S_DIG: if (!go_q && dig_done) st_q <= S_SEND;
				S_SEND: st_q <= S_WAIT;
				S_WAIT: if (!emit_busy) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && s_axis_tvalid) begin
			kind_q <= in_kind;
			mag_q <= m;
			neg_q <= sbit;
			left_q <= s_axis_tdata[66];
			plus_q <= s_axis_tdata[67];
			space_q <= s_axis_tdata[68];
			alt_q <= s_axis_tdata[69];
			zero_q <= s_axis_tdata[70];
			fw_q <= in_fw;
			hasp_q <= s_axis_tdata[77];
			md_q <= in_md;
		end
	end

`ifndef ASSERT_OFF
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> !m_axis_tvalid)
		else $error("output while idle");
	a_go_once: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> (st_q == S_DIG))
		else $error("digit start outside digit phase");
	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SEND) |=> emit_busy)
		else $error("emitter did not start");
`endif
endmodule
